// ===== src/paf_pkg.sv =====
// Package for the Pareto archive filter: sizes, payload words, entry layout,
// compare result and sequencer states. No dependencies.
`default_nettype none

package paf_pkg;

    // Archive geometry
    localparam int CAPACITY = 32;
    localparam int NUM_OBJ  = 4;
    localparam int OBJ_W    = 32;
    localparam int ORD_W    = 32;
    localparam int MASK_W   = 4;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

    // Input word: one candidate
    typedef struct packed {
        logic signed [OBJ_W-1:0] obj_0;
        logic signed [OBJ_W-1:0] obj_1;
        logic signed [OBJ_W-1:0] obj_2;
        logic signed [OBJ_W-1:0] obj_3;
    } t_in_word;

    // Result word: removal notice or final verdict
    typedef struct packed {
        logic             is_final;
        logic [ORD_W-1:0] removed_ordinal;
        logic             was_added;
        logic             was_dominated;
        logic             archive_full;
        logic [ORD_W-1:0] current_ordinal;
        logic             last;
    } t_out_word;

    // Objective vector, lane i holds objective i
    typedef logic [NUM_OBJ-1:0][OBJ_W-1:0] t_objs;

    // One archive slot
    typedef struct packed {
        logic [ORD_W-1:0] ordinal;
        t_objs            objs;
    } t_entry;

    // Dominance compare outcome
    typedef struct packed {
        logic entry_better;
        logic cand_better;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MOVE,
        ST_APPEND
    } t_state;

endpackage

`default_nettype wire

// ===== src/paf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module paf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/paf_cmp.sv =====
// Shared dominance compare unit: one stored entry against the candidate.
// Depends on paf_pkg.
`default_nettype none

module paf_cmp
    import paf_pkg::*;
(
    input  wire logic [MASK_W-1:0] i_mask,
    input  wire t_objs             i_cand,
    input  wire t_objs             i_entry,
    output t_cmp                   o_res
);

    logic [NUM_OBJ-1:0] lane_lt;
    logic [NUM_OBJ-1:0] lane_gt;

    // Compare each enabled objective as signed; lanes without a mask bit stay off
    for (genvar g = 0; g < NUM_OBJ; g++) begin : g_lane
        if (g < MASK_W) begin : g_on
            assign lane_lt[g] = i_mask[g] &&
                                ($signed(i_entry[g]) < $signed(i_cand[g]));
            assign lane_gt[g] = i_mask[g] &&
                                ($signed(i_entry[g]) > $signed(i_cand[g]));
        end else begin : g_off
            assign lane_lt[g] = 1'b0;
            assign lane_gt[g] = 1'b0;
        end
    end

    assign o_res.entry_better = |lane_lt;
    assign o_res.cand_better  = |lane_gt;

endmodule

`default_nettype wire

// ===== src/pareto_archive_filter_unit.sv =====
// Top level of the Pareto archive filter: walk sequencer, archive RAM and
// compare unit. Depends on paf_pkg, paf_ram and paf_cmp.
//
//  channel   signals                           direction  transfer
//  command   i_start, o_busy, i_in             in         i_start && !o_busy
//  result    o_result_valid, o_result          out        o_result_valid (no stall)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data in      i_cfg_valid && o_cfg_ready
//
// For one candidate the walk reads archive entries in turn and ends with
// the verdict word: the archive RAM gives one entry per cycle to the shared
// compare unit while no entry is dropped, and each drop costs a move of the
// last entry into the hole and a fresh read of that slot (a drop of the last
// slot itself has no move). Reset is synchronous and empties the archive; no
// clearing pass is needed. Result words come at most one per cycle for one
// cycle each, and the receiver cannot stall them.
`default_nettype none

module pareto_archive_filter_unit
    import paf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_in_word          i_in,
    output logic                   o_result_valid,
    output t_out_word              o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MASK_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ORD_W-1:0]  r_ord, n_ord;
    logic [MASK_W-1:0] r_mask;
    t_objs             r_cand, n_cand;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;
    t_cmp              cmp_res;
    logic [CNT_W-1:0]  last_pos;

    paf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    paf_cmp u_cmp (
        .i_mask  (r_mask),
        .i_cand  (r_cand),
        .i_entry (ram_rdata.objs),
        .o_res   (cmp_res)
    );

    assign o_busy         = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign last_pos       = r_count - CNT_W'(1);

    // Sequence the walk: read, compare, drop and move, append
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_ord       = r_ord;
        n_cand      = r_cand;
        n_out       = '0;
        n_out_valid = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[ADDR_W-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                // Latch the candidate word
                if (i_start) begin
                    n_cand[0] = i_in.obj_0;
                    n_cand[1] = i_in.obj_1;
                    n_cand[2] = i_in.obj_2;
                    n_cand[3] = i_in.obj_3;
                    n_idx     = '0;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                if (r_idx < r_count) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_APPEND;
                end
            end
            ST_CMP: begin
                priority if (!cmp_res.entry_better && !cmp_res.cand_better) begin
                    // Equal entry: reject
                    n_out_valid           = 1'b1;
                    n_out.is_final        = 1'b1;
                    n_out.current_ordinal = r_ord;
                    n_out.last            = 1'b1;
                    n_state               = ST_IDLE;
                end else if (cmp_res.entry_better && cmp_res.cand_better) begin
                    // Incomparable: advance, read the next slot ahead
                    n_idx     = r_idx + CNT_W'(1);
                    ram_raddr = n_idx[ADDR_W-1:0];
                    if (n_idx < r_count) begin
                        n_state = ST_CMP;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end else if (cmp_res.entry_better) begin
                    // Dominated by the entry: reject
                    n_out_valid           = 1'b1;
                    n_out.is_final        = 1'b1;
                    n_out.was_dominated   = 1'b1;
                    n_out.current_ordinal = r_ord;
                    n_out.last            = 1'b1;
                    n_state               = ST_IDLE;
                end else begin
                    // Drop the entry, fetch the last one to fill the hole
                    n_out_valid           = 1'b1;
                    n_out.removed_ordinal = ram_rdata.ordinal;
                    n_count               = last_pos;
                    ram_raddr             = last_pos[ADDR_W-1:0];
                    if (last_pos != r_idx) begin
                        n_state = ST_MOVE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_MOVE: begin
                // Write the last entry into the dropped slot, then examine it
                ram_we    = 1'b1;
                ram_waddr = r_idx[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                n_state   = ST_READ;
            end
            ST_APPEND: begin
                n_out_valid    = 1'b1;
                n_out.is_final = 1'b1;
                n_out.last     = 1'b1;
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_out.archive_full    = 1'b1;
                    n_out.current_ordinal = r_ord;
                end else begin
                    n_ord                 = r_ord + ORD_W'(1);
                    ram_we                = 1'b1;
                    ram_waddr             = r_count[ADDR_W-1:0];
                    ram_wdata.ordinal     = n_ord;
                    ram_wdata.objs        = r_cand;
                    n_count               = r_count + CNT_W'(1);
                    n_out.was_added       = 1'b1;
                    n_out.current_ordinal = n_ord;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state; reset clears it and sets the mask to all objectives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ord       <= '0;
            r_mask      <= MASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ord       <= n_ord;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cand <= n_cand;
        r_out  <= n_out;
    end

    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("archive count beyond capacity");

    // The verdict word leaves the block ready for the next candidate
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !o_busy)
        else $error("busy after final verdict");

    // An accepted candidate makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("start not taken");

    // An added candidate grows the archive by one
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.was_added) |->
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not grow the archive");

endmodule

`default_nettype wire
